/* rtl/bif_pkg.sv */
// shared constants, types and codes for the border index fold block
package bif_pkg;

  // field widths
  localparam int COORD_BITS = 17;
  localparam int SIZE_BITS  = 16;
  // fold period is up to twice the size
  localparam int P_BITS     = SIZE_BITS + 1;
  localparam int CMP_BITS   = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int CNT_BITS   = $clog2(COORD_BITS);
  localparam int MODE_BITS  = 3;

  // border mode codes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_CONSTANT   = 3'd0,
    MODE_REPLICATE  = 3'd1,
    MODE_REFLECT    = 3'd2,
    MODE_WRAP       = 3'd3,
    MODE_REFLECT101 = 3'd4
  } bif_mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADJ,
    ST_DONE
  } bif_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic adjust;
    logic emit;
  } bif_cmd_t;

endpackage

/* rtl/border_index_fold.sv */
// top level of the border index fold block
// Maps a signed coordinate into 0..dim_size-1 under the border mode held in
// the configuration register (constant, replicate, reflect, wrap, reflect101;
// codes 5 to 7 give index 0 with bad_mode set). One word is worked at a time:
// after acceptance the remainder unit spends one cycle per coordinate bit,
// then the sign is fixed, and the folded result is loaded into the output
// register once that register is free or being drained; only then is a new
// word taken. The output register lets the next word be accepted while a
// finished word still waits. Write the mode only while the block is idle.
module border_index_fold (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bif_pkg::MODE_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bif_pkg::COORD_BITS-1:0] coord,
  input  logic [bif_pkg::SIZE_BITS-1:0]         dim_size,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bif_pkg::SIZE_BITS-1:0]         index,
  output logic                                  bad_mode
);
  import bif_pkg::*;

  bif_cmd_t cmd;

  // sequencer
  bif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and result register
  bif_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .coord    (coord),
    .dim_size (dim_size),
    .cmd      (cmd),
    .index    (index),
    .bad_mode (bad_mode)
  );

endmodule

/* rtl/bif_ctrl.sv */
// controller: sequences load, division steps, sign fix and result emit
module bif_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bif_pkg::bif_cmd_t cmd
);
  import bif_pkg::*;

  bif_state_t          state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                out_valid_next;

  // state, step count and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(COORD_BITS - 1)) begin
          state_next = ST_ADJ;
        end
      end
      ST_ADJ: begin
        cmd.adjust = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hand off once the output register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

/* rtl/bif_datapath.sv */
// datapath: mode register, restoring remainder unit, fold and output register
module bif_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bif_pkg::MODE_BITS-1:0]    cfg_data,
  input  logic signed [bif_pkg::COORD_BITS-1:0] coord,
  input  logic [bif_pkg::SIZE_BITS-1:0]    dim_size,
  input  bif_pkg::bif_cmd_t                cmd,
  output logic [bif_pkg::SIZE_BITS-1:0]    index,
  output logic                             bad_mode
);
  import bif_pkg::*;

  logic [MODE_BITS-1:0]  mode;
  logic                  neg;
  logic [COORD_BITS-1:0] xmag;
  logic [COORD_BITS-1:0] dvd;
  logic [SIZE_BITS-1:0]  size;
  logic [P_BITS-1:0]     p;
  logic [P_BITS-1:0]     rem;

  logic [COORD_BITS-1:0] mag_in;
  logic [P_BITS-1:0]     p_in;
  logic [P_BITS:0]       rem_sh;
  logic [P_BITS-1:0]     rem_step;
  logic                  bad;
  logic                  in_range;
  logic                  rem_hi;
  logic [SIZE_BITS-1:0]  result;

  // border mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CONSTANT;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  // magnitude of the coordinate and fold period for the current mode
  always_comb begin
    mag_in = coord[COORD_BITS-1] ? COORD_BITS'(-coord) : COORD_BITS'(coord);
    case (mode)
      MODE_REFLECT:    p_in = {dim_size, 1'b0};
      MODE_REFLECT101: p_in = {dim_size, 1'b0} - P_BITS'(2);
      default:         p_in = {1'b0, dim_size};
    endcase
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, dvd[COORD_BITS-1]};
    rem_step = rem_sh[P_BITS-1:0];
    if (rem_sh >= {1'b0, p}) begin
      rem_step = P_BITS'(rem_sh - {1'b0, p});
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= coord[COORD_BITS-1];
      xmag <= mag_in;
      dvd  <= mag_in;
      size <= dim_size;
      p    <= p_in;
      rem  <= '0;
    end else if (cmd.step) begin
      dvd <= dvd << 1;
      rem <= rem_step;
    end else if (cmd.adjust) begin
      // negative coordinate: bring the remainder into 0..p-1
      if (neg && (rem != '0)) begin
        rem <= p - rem;
      end
    end
  end

  // final fold per mode
  always_comb begin
    bad      = (mode > MODE_BITS'(MODE_REFLECT101));
    in_range = !neg && (CMP_BITS'(xmag) < CMP_BITS'(size));
    rem_hi   = (rem >= {1'b0, size});
    result   = '0;
    if (!bad && (size != '0)) begin
      case (mode)
        MODE_CONSTANT: begin
          result = in_range ? SIZE_BITS'(xmag) : '0;
        end
        MODE_REPLICATE: begin
          if (neg) begin
            result = '0;
          end else if (in_range) begin
            result = SIZE_BITS'(xmag);
          end else begin
            result = size - SIZE_BITS'(1);
          end
        end
        MODE_REFLECT: begin
          result = rem_hi ? SIZE_BITS'(p - P_BITS'(1) - rem) : SIZE_BITS'(rem);
        end
        MODE_WRAP: begin
          result = SIZE_BITS'(rem);
        end
        MODE_REFLECT101: begin
          if (size == SIZE_BITS'(1)) begin
            result = '0;
          end else begin
            result = rem_hi ? SIZE_BITS'(p - rem) : SIZE_BITS'(rem);
          end
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      index    <= result;
      bad_mode <= bad;
    end
  end

endmodule

/* rtl/bif_checker.sv */
// port-level checks for the border index fold block and their binding
module bif_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_we,
  input logic [bif_pkg::MODE_BITS-1:0]         cfg_data,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [bif_pkg::COORD_BITS-1:0] coord,
  input logic [bif_pkg::SIZE_BITS-1:0]         dim_size,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [bif_pkg::SIZE_BITS-1:0]         index,
  input logic                                  bad_mode
);
  import bif_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(index) && $stable(bad_mode))
    else $error("output word changed while stalled");

  // an unsupported mode always reports index zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_mode |-> index == '0)
    else $error("bad mode with nonzero index");

  // one word in flight: intake closes right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("second word taken while busy");

  // reset leaves an empty output and open intake
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind border_index_fold bif_checker u_bif_checker (.*);

/* tb/sv/tb.sv */
// testbench for the border index fold block: directed, random and back-pressure tests
`timescale 1ns / 1ps

module tb;
  import bif_pkg::*;

  // unsupported mode codes
  localparam logic [MODE_BITS-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_RSVD7 = 3'd7;

  // settle time per word, used for the final wait
  localparam int FOLD_LATENCY = COORD_BITS + 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_WORDS  = 110;
  localparam int STREAM_WORDS = 240;

  typedef struct packed {
    logic [SIZE_BITS-1:0] idx;
    logic                 bad;
  } fold_result_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [MODE_BITS-1:0]         cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] coord;
  logic [SIZE_BITS-1:0]         dim_size;
  logic                         out_valid;
  logic                         out_ready;
  logic [SIZE_BITS-1:0]         index;
  logic                         bad_mode;

  // predictor state and result store
  logic [MODE_BITS-1:0] cur_mode;
  fold_result_t         expected_folds[$];
  fold_result_t         head_fold;
  int                   fail_count;
  bit                   idle_on;
  bit                   hold_request;

  border_index_fold u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coord     (coord),
    .dim_size  (dim_size),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .index     (index),
    .bad_mode  (bad_mode)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // remainder that is never negative
  function automatic longint floor_mod(longint x, longint p);
    longint r;
    r = x % p;
    if (r < 0) r += p;
    return r;
  endfunction

  // expected index and error flag for one word
  function automatic fold_result_t fold_coord(logic [MODE_BITS-1:0] mode,
      logic signed [COORD_BITS-1:0] c, logic [SIZE_BITS-1:0] s);
    fold_result_t res;
    longint x, n, p, m, r;
    x = longint'(c);
    n = longint'(s);
    r = 0;
    res.bad = (mode > MODE_REFLECT101);
    if (!res.bad && n > 0) begin
      case (mode)
        MODE_CONSTANT:  r = (x < 0 || x >= n) ? 0 : x;
        MODE_REPLICATE: r = (x < 0) ? 0 : ((x > n - 1) ? n - 1 : x);
        MODE_REFLECT: begin
          p = 2 * n;
          m = floor_mod(x, p);
          r = (m >= n) ? p - 1 - m : m;
        end
        MODE_WRAP:      r = floor_mod(x, n);
        MODE_REFLECT101: begin
          // size one folds onto itself
          if (n == 1) begin
            r = 0;
          end else begin
            p = 2 * n - 2;
            m = floor_mod(x, p);
            r = (m >= n) ? p - m : m;
          end
        end
        default:        r = 0;
      endcase
    end
    res.idx = r[SIZE_BITS-1:0];
    return res;
  endfunction

  // random size, mostly small
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return SIZE_BITS'($urandom_range(1, 16));
    if (sel < 8) return SIZE_BITS'($urandom_range(1, 65535));
    if (sel == 8) begin
      case ($urandom_range(0, 2))
        0:       return 16'd1;
        1:       return 16'd2;
        default: return 16'd65535;
      endcase
    end
    if ($urandom_range(0, 3) == 0) return 16'd0;
    return SIZE_BITS'($urandom_range(17, 300));
  endfunction

  // random coordinate, mostly within a few periods of the size
  function automatic logic signed [COORD_BITS-1:0] pick_coord(logic [SIZE_BITS-1:0] s);
    int sel, span, off;
    logic [31:0] raw;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      span = 3 * int'(s) + 4;
      off = int'($urandom_range(0, 2 * span)) - span;
      return off[COORD_BITS-1:0];
    end
    if (sel < 9) begin
      raw = $urandom();
      return raw[COORD_BITS-1:0];
    end
    case ($urandom_range(0, 3))
      0:       return COORD_BITS'(-65536);
      1:       return COORD_BITS'(65535);
      2:       return COORD_BITS'(-1);
      default: return COORD_BITS'(0);
    endcase
  endfunction

  // offer one word and wait for its acceptance, valid stays high afterwards
  task automatic send_word(int c, logic [SIZE_BITS-1:0] s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    coord    <= COORD_BITS'(c);
    dim_size <= s;
    do @(posedge clk); while (!in_ready);
    expected_folds.push_back(fold_coord(cur_mode, COORD_BITS'(c), s));
  endtask

  // stop offering and wait for every result
  task automatic drain_words();
    in_valid <= 1'b0;
    while (expected_folds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the border mode while idle
  task automatic write_mode(logic [MODE_BITS-1:0] m);
    drain_words();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  // constant mode straight out of reset
  task automatic test_reset_mode();
    send_word(-1, 16'd5);
    send_word(0, 16'd5);
    send_word(4, 16'd5);
    send_word(5, 16'd5);
    send_word(65535, 16'd65535);
    send_word(-65536, 16'd65535);
  endtask

  // edges of the replicate, reflect, wrap and reflect101 modes, unsupported codes and zero size
  task automatic test_modes_directed();
    write_mode(MODE_REPLICATE);
    send_word(-65536, 16'd7);
    send_word(65535, 16'd7);
    send_word(3, 16'd7);
    write_mode(MODE_REFLECT);
    send_word(-1, 16'd4);
    send_word(4, 16'd4);
    send_word(-65536, 16'd65535);
    send_word(65535, 16'd1);
    write_mode(MODE_WRAP);
    send_word(-1, 16'd3);
    send_word(65535, 16'd65535);
    send_word(-65536, 16'd3);
    send_word(9, 16'd0);
    write_mode(MODE_REFLECT101);
    send_word(5, 16'd1);
    send_word(-1, 16'd4);
    send_word(6, 16'd4);
    send_word(65535, 16'd2);
    send_word(-65536, 16'd65535);
    write_mode(MODE_RSVD5);
    send_word(3, 16'd8);
    write_mode(MODE_RSVD6);
    send_word(-3, 16'd8);
    write_mode(MODE_RSVD7);
    send_word(2, 16'd0);
  endtask

  // random words over many mode settings with idling on both sides
  task automatic test_random_phases();
    logic [SIZE_BITS-1:0] s;
    idle_on = 1'b1;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 8) write_mode(MODE_BITS'(ph));
      else write_mode(MODE_BITS'($urandom_range(0, 7)));
      // some phases run with no idling at all
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        s = pick_size();
        send_word(pick_coord(s), s);
      end
    end
  endtask

  // receiver holds off long enough that the input stalls
  task automatic test_output_hold();
    logic [SIZE_BITS-1:0] s;
    write_mode(MODE_REFLECT);
    idle_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      s = pick_size();
      send_word(pick_coord(s), s);
    end
  endtask

  // back-to-back words with no idling
  task automatic test_streaming();
    logic [SIZE_BITS-1:0] s;
    idle_on = 1'b0;
    for (int i = 0; i < STREAM_WORDS; i++) begin
      if (i % 60 == 0) write_mode(MODE_BITS'($urandom_range(0, 7)));
      s = pick_size();
      send_word(pick_coord(s), s);
    end
  endtask

  // receiver: random stalls and one long hold
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_folds.size() == 0) begin
        $error("unexpected result word: index %0d bad_mode %0d", index, bad_mode);
        fail_count++;
      end else begin
        head_fold = expected_folds.pop_front();
        if (index !== head_fold.idx) begin
          $error("index mismatch: expected %0d, actual %0d", head_fold.idx, index);
          fail_count++;
        end
        if (bad_mode !== head_fold.bad) begin
          $error("bad_mode mismatch: expected %0d, actual %0d", head_fold.bad, bad_mode);
          fail_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    fail_count   = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    cur_mode     = MODE_CONSTANT;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= MODE_CONSTANT;
    in_valid <= 1'b0;
    coord    <= '0;
    dim_size <= 16'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_mode();
    test_modes_directed();
    test_random_phases();
    test_output_hold();
    test_streaming();

    drain_words();
    repeat (2 * FOLD_LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
